// ===== hdl/dss_pkg.sv =====
package dss_pkg;

    localparam int DEPTH  = 16;
    localparam int WORD_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [ADDR_W-1:0] ADDR_MAX  = ADDR_W'(DEPTH - 1);

    // opcodes
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_DUMP = 2'd2;

    // result status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_OVER  = 2'd1;
    localparam logic [1:0] STS_UNDER = 2'd2;
    localparam logic [1:0] STS_EMPTY = 2'd3;

    typedef struct packed {
        logic       wr_push;     // accepted push, store has room
        logic       rd_pop;      // accepted pop, side not empty
        logic       ld_flag;     // error or empty result, no store access
        logic [1:0] status;
        logic       side;
        logic       dump_init;
        logic       dump_issue;  // read next dump entry
        logic       out_load;    // move pending result into output register
    } cmd_t;

    typedef struct packed {
        logic full;
        logic low_empty;
        logic high_empty;
        logic dump_final;
        logic out_free;
        logic pend_last;
    } sts_t;

endpackage

// ===== hdl/dss_ctrl.sv =====
module dss_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic [1:0]    opcode,
    input  logic          side,
    input  dss_pkg::sts_t sts,
    output logic          s_tready,
    output dss_pkg::cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EMIT = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       pend_vld_reg, pend_vld_next;
    logic       dump_more_reg, dump_more_next;
    logic       load_out;
    logic       issue;
    logic       side_empty;

    assign s_tready   = (state_reg == S_IDLE);
    assign side_empty = side ? sts.high_empty : sts.low_empty;
    assign load_out   = pend_vld_reg && sts.out_free;
    assign issue      = dump_more_reg && (!pend_vld_reg || load_out);

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        pend_vld_next  = pend_vld_reg;
        dump_more_next = dump_more_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    unique case (opcode)
                        dss_pkg::OP_PUSH: begin
                            cmd.side = side;
                            if (sts.full) begin
                                cmd.ld_flag = 1'b1;
                                cmd.status  = dss_pkg::STS_OVER;
                            end else begin
                                cmd.wr_push = 1'b1;
                                cmd.status  = dss_pkg::STS_OK;
                            end
                            state_next = S_EMIT;
                        end
                        dss_pkg::OP_POP: begin
                            cmd.side = side;
                            if (side_empty) begin
                                cmd.ld_flag = 1'b1;
                                cmd.status  = dss_pkg::STS_UNDER;
                            end else begin
                                cmd.rd_pop = 1'b1;
                                cmd.status = dss_pkg::STS_OK;
                            end
                            state_next = S_EMIT;
                        end
                        dss_pkg::OP_DUMP: begin
                            if (sts.low_empty && sts.high_empty) begin
                                cmd.ld_flag = 1'b1;
                                cmd.status  = dss_pkg::STS_EMPTY;
                                cmd.side    = 1'b0;
                                state_next  = S_EMIT;
                            end else begin
                                cmd.dump_init  = 1'b1;
                                pend_vld_next  = 1'b0;
                                dump_more_next = 1'b1;
                                state_next     = S_DUMP;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DUMP: begin
                cmd.out_load   = load_out;
                cmd.dump_issue = issue;
                if (issue) begin
                    pend_vld_next  = 1'b1;
                    dump_more_next = !sts.dump_final;
                end else if (load_out) begin
                    pend_vld_next = 1'b0;
                end
                if (load_out && sts.pend_last) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pend_vld_reg  <= 1'b0;
            dump_more_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_vld_reg  <= pend_vld_next;
            dump_more_reg <= dump_more_next;
        end
    end

endmodule

// ===== hdl/dss_dpath.sv =====
module dss_dpath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  dss_pkg::cmd_t              cmd,
    input  logic                       side,
    input  logic [dss_pkg::WORD_W-1:0] push_value,
    input  logic                       m_tready,
    output dss_pkg::sts_t              sts,
    output logic                       m_valid,
    output logic [dss_pkg::WORD_W-1:0] m_data,
    output logic [1:0]                 m_status,
    output logic                       m_side,
    output logic                       m_last
);

    localparam int CW = dss_pkg::CNT_W;
    localparam int AW = dss_pkg::ADDR_W;
    localparam int WW = dss_pkg::WORD_W;

    logic [WW-1:0] word_mem [dss_pkg::DEPTH];
    logic [WW-1:0] rd_data_reg;

    logic [CW-1:0] low_count_reg, low_count_next;
    logic [CW-1:0] high_start_reg, high_start_next;
    logic [CW-1:0] low_dec;
    logic [CW-1:0] high_dec;

    logic [AW-1:0] dump_addr_reg, dump_addr_next;
    logic          dump_side_reg, dump_side_next;

    logic [WW-1:0] pend_data_reg, pend_data_next;
    logic [1:0]    pend_status_reg, pend_status_next;
    logic          pend_side_reg, pend_side_next;
    logic          pend_last_reg, pend_last_next;
    logic          pend_use_rd_reg, pend_use_rd_next;

    logic          m_valid_reg, m_valid_next;
    logic [WW-1:0] m_data_reg, m_data_next;
    logic [1:0]    m_status_reg, m_status_next;
    logic          m_side_reg, m_side_next;
    logic          m_last_reg, m_last_next;

    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic          low_end;

    assign low_dec  = low_count_reg - CW'(1);
    assign high_dec = high_start_reg - CW'(1);
    assign low_end  = (CW'(dump_addr_reg) == low_dec);

    assign sts.full       = (low_count_reg == high_start_reg);
    assign sts.low_empty  = (low_count_reg == '0);
    assign sts.high_empty = (high_start_reg == dss_pkg::DEPTH_CNT);
    assign sts.dump_final = dump_side_reg ? (CW'(dump_addr_reg) == high_start_reg)
                                          : (low_end && sts.high_empty);
    assign sts.out_free   = !m_valid_reg || m_tready;
    assign sts.pend_last  = pend_last_reg;

    assign mem_we    = cmd.wr_push;
    assign mem_waddr = side ? high_dec[AW-1:0] : low_count_reg[AW-1:0];
    assign mem_re    = cmd.rd_pop || cmd.dump_issue;
    assign mem_raddr = cmd.dump_issue ? dump_addr_reg
                     : (side ? high_start_reg[AW-1:0] : low_dec[AW-1:0]);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            word_mem[mem_waddr] <= push_value;
        end
        if (mem_re) begin
            rd_data_reg <= word_mem[mem_raddr];
        end
    end

    always_comb begin
        low_count_next  = low_count_reg;
        high_start_next = high_start_reg;
        if (cmd.wr_push) begin
            if (side) begin
                high_start_next = high_dec;
            end else begin
                low_count_next = low_count_reg + CW'(1);
            end
        end else if (cmd.rd_pop) begin
            if (side) begin
                high_start_next = high_start_reg + CW'(1);
            end else begin
                low_count_next = low_dec;
            end
        end
    end

    always_comb begin
        dump_addr_next = dump_addr_reg;
        dump_side_next = dump_side_reg;
        if (cmd.dump_init) begin
            dump_side_next = sts.low_empty;
            dump_addr_next = sts.low_empty ? dss_pkg::ADDR_MAX : '0;
        end else if (cmd.dump_issue) begin
            if (dump_side_reg) begin
                dump_addr_next = dump_addr_reg - AW'(1);
            end else if (low_end) begin
                dump_side_next = 1'b1;
                dump_addr_next = dss_pkg::ADDR_MAX;
            end else begin
                dump_addr_next = dump_addr_reg + AW'(1);
            end
        end
    end

    always_comb begin
        pend_data_next   = pend_data_reg;
        pend_status_next = pend_status_reg;
        pend_side_next   = pend_side_reg;
        pend_last_next   = pend_last_reg;
        pend_use_rd_next = pend_use_rd_reg;
        if (cmd.wr_push || cmd.rd_pop || cmd.ld_flag) begin
            pend_data_next   = cmd.wr_push ? push_value : '0;
            pend_status_next = cmd.status;
            pend_side_next   = cmd.side;
            pend_last_next   = 1'b1;
            pend_use_rd_next = cmd.rd_pop;
        end else if (cmd.dump_issue) begin
            pend_status_next = dss_pkg::STS_OK;
            pend_side_next   = dump_side_reg;
            pend_last_next   = sts.dump_final;
            pend_use_rd_next = 1'b1;
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_side_next   = m_side_reg;
        m_last_next   = m_last_reg;
        if (cmd.out_load) begin
            m_valid_next  = 1'b1;
            m_data_next   = pend_use_rd_reg ? rd_data_reg : pend_data_reg;
            m_status_next = pend_status_reg;
            m_side_next   = pend_side_reg;
            m_last_next   = pend_last_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_count_reg  <= '0;
            high_start_reg <= dss_pkg::DEPTH_CNT;
            m_valid_reg    <= 1'b0;
        end else begin
            low_count_reg  <= low_count_next;
            high_start_reg <= high_start_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dump_addr_reg   <= dump_addr_next;
        dump_side_reg   <= dump_side_next;
        pend_data_reg   <= pend_data_next;
        pend_status_reg <= pend_status_next;
        pend_side_reg   <= pend_side_next;
        pend_last_reg   <= pend_last_next;
        pend_use_rd_reg <= pend_use_rd_next;
        m_data_reg      <= m_data_next;
        m_status_reg    <= m_status_next;
        m_side_reg      <= m_side_next;
        m_last_reg      <= m_last_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign m_status = m_status_reg;
    assign m_side   = m_side_reg;
    assign m_last   = m_last_reg;

endmodule

// ===== hdl/dual_stack_shared_array.sv =====
// two stacks sharing one 16-word store: the low stack grows up from entry 0,
// the high stack grows down from the top entry
// input channel (s_): one transaction is a push, a pop or a dump; tuser carries
// the opcode and the side, tdata the word to push
// result channel (m_): tdata is the word, tuser carries status and side,
// tlast marks the final result of each input transaction
// push and pop give one result, held in the pending register until the output
// register is free and then moved into it; the next input is taken only once
// the result has entered the output register
// a dump reads the store through its single registered read port, one entry
// per cycle unless the receiver stalls, and gives one result per stored word
// with last on the final one; with both stacks empty, one empty-status result
// an unused opcode is dropped with no result
// when the receiver stalls, the result holds in the output register and the
// block takes one more input, then waits before producing further results
// reset clears both stack pointers (both sides empty) and the output valid;
// store contents are not cleared, and no entry is read before it is written
module dual_stack_shared_array (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // push_value
    input  logic [2:0]  s_tuser,   // opcode [1:0], side [2]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // data_word
    output logic [2:0]  m_tuser,   // status [1:0], from_side [2]
    output logic        m_tlast
);

    dss_pkg::cmd_t cmd;
    dss_pkg::sts_t sts;

    logic [1:0] m_status;
    logic       m_side;

    // sequencing: accept, error decisions, dump walk
    dss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .opcode   (s_tuser[1:0]),
        .side     (s_tuser[2]),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // store, stack pointers, pending result and output register
    dss_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .side       (s_tuser[2]),
        .push_value (s_tdata),
        .m_tready   (m_tready),
        .sts        (sts),
        .m_valid    (m_tvalid),
        .m_data     (m_tdata),
        .m_status   (m_status),
        .m_side     (m_side),
        .m_last     (m_tlast)
    );

    assign m_tuser = {m_side, m_status};

endmodule

// ===== hdl/dss_checker.sv =====
module dss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // error and empty results carry a zero word and end the transaction
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] != dss_pkg::STS_OK |-> m_tdata == 32'd0 && m_tlast)
        else $error("error result with data or without last");

    // empty status only comes from a dump and names the low side
    a_empty_side: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == dss_pkg::STS_EMPTY |-> !m_tuser[2])
        else $error("empty status with high side");

    // every valid opcode moves the block out of idle, so input is not taken back to back
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[1:0] != 2'd3 |=> !s_tready)
        else $error("input taken back to back");

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind dual_stack_shared_array dss_checker u_dss_checker (.*);
